// ===== src/mtsm_pkg.sv =====
// shared constants, register codes and the sine table generator for the tone mixer
package mtsm_pkg;

  // parameter defaults
  localparam int NUM_TONES_DEF       = 6;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  // field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MASK_W     = 6;
  localparam int AMP_W      = 15;
  localparam int STEP_W     = 32;
  localparam int SINE_W     = 15;
  localparam int PROD_W     = AMP_W + SINE_W;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 3;

  // only the first six tones have enable bits and step registers
  localparam int STEP_REGS = 6;

  // mix sum: at most six products of 15 x 15 bits, signed
  localparam int SUM_W         = 35;
  // magnitude of the sum after the divide by 32768
  localparam int SUM_SHIFT     = 15;
  localparam int DIV_NUM_W     = 18;
  localparam int DIV_STEP_BITS = 3;
  localparam int DIV_REM_W     = COUNT_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'd32767;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE0_STEP  = 3'd2;

  localparam logic [MASK_W-1:0] ENABLE_MASK_RST = 6'd63;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd2000;

  localparam logic [STEP_W-1:0] DEFAULT_STEPS [16] = '{
    32'd21426141, 32'd42852281, 32'd85704563, 32'd171409126,
    32'd342818251, 32'd685636503, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [DIV_NUM_W-1:0] numer;
    logic [COUNT_W-1:0]   denom;
  } mtsm_div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
  } mtsm_div_rsp_t;

  // quarter-wave sine in q15, taylor series to the x^13 term in q30
  // only evaluated at elaboration to fill the lookup table
  function automatic logic [SINE_W-1:0] quarter_sine(longint unsigned r, int tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    x    = (r * HALF_PI_Q30) >> (tbits - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 72;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 110;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 156;
    acc  = acc + term;
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

// ===== src/mtsm_divider.sv =====
// iterative divide of the mix magnitude by the active tone count, with clamp and sign
module mtsm_divider
  import mtsm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mtsm_div_req_t req_i,
  output mtsm_div_rsp_t rsp_o
);

  localparam int STEPS = DIV_NUM_W / DIV_STEP_BITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0]       num_q, num_d;
  logic [DIV_NUM_W-1:0]       quo_q, quo_d;
  logic [DIV_REM_W-1:0]       rem_q, rem_d;
  logic [COUNT_W-1:0]         den_q, den_d;
  logic                       neg_q, neg_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  logic [DIV_NUM_W-1:0]       quo_step;
  logic [DIV_REM_W-1:0]       rem_step;
  logic [SAMPLE_W-1:0]        mag;

  // restoring steps unrolled over DIV_STEP_BITS numerator bits, taken msb first
  always_comb begin
    logic [DIV_REM_W:0] trial;
    quo_step = quo_q;
    rem_step = rem_q;
    for (int b = 0; b < DIV_STEP_BITS; b++) begin
      trial = {rem_step, num_q[DIV_NUM_W-1-b]};
      if (trial >= {2'b00, den_q}) begin
        trial    = trial - {2'b00, den_q};
        quo_step = {quo_step[DIV_NUM_W-2:0], 1'b1};
      end else begin
        quo_step = {quo_step[DIV_NUM_W-2:0], 1'b0};
      end
      rem_step = trial[DIV_REM_W-1:0];
    end
  end

  always_comb begin
    if (quo_step > DIV_NUM_W'(SAMPLE_MAX)) begin
      mag = SAMPLE_MAX;
    end else begin
      mag = quo_step[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    num_d    = num_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    den_d    = den_q;
    neg_d    = neg_q;
    sample_d = sample_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.numer;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = req_i.denom;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      num_d = {num_q[DIV_NUM_W-DIV_STEP_BITS-1:0], {DIV_STEP_BITS{1'b0}}};
      quo_d = quo_step;
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // no tone enabled gives silence
        if (den_q == '0) begin
          sample_d = '0;
        end else if (neg_q) begin
          sample_d = -$signed(mag);
        end else begin
          sample_d = $signed(mag);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    sample_q <= sample_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.sample = sample_q;

endmodule

// ===== src/multi_tone_sine_mixer.sv =====
// top level of the multi-tone sine mixer: phase memory, tone pipeline and output register
//
// usage:
//   each transaction on the tick channel (tick_valid_i high, tick_stall_o low)
//   with tick_i set produces one stereo sample; tick_i clear is taken and
//   dropped without changing any phase
//   tones are walked one per cycle: phase read from the phase memory, written
//   back advanced by its step, sine looked up from a quarter-wave table,
//   scaled by the amplitude and summed; the sum is then divided by the number
//   of enabled tones in a divider that retires three quotient bits a cycle;
//   tick_stall_o is high while one sample is in work, from the taken tick
//   until the sample is loaded into the output register, so a new tick is
//   taken only once the last one is through the tone walk and the divider;
//   the sample channel (sample_valid_o / sample_stall_i) has its own output
//   register, so a new tick is taken while a sample waits; a finished sample
//   holds inside until that register is free
//   configuration writes are taken at any edge with cfg_we_i high and must
//   only come while no sample is in work
//   reset clears the phases through per-tone valid bits, loads the register
//   defaults and empties the output register; no clearing pass is needed
module multi_tone_sine_mixer
  import mtsm_pkg::*;
#(
  parameter int NUM_TONES       = NUM_TONES_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_valid_i,
  output logic                       tick_stall_o,
  input  logic                       tick_i,
  output logic                       sample_valid_o,
  input  logic                       sample_stall_i,
  output logic signed [SAMPLE_W-1:0] left_sample_o,
  output logic signed [SAMPLE_W-1:0] right_sample_o,
  output logic [COUNT_W-1:0]         active_tones_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int TONE_W  = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int QA_W    = SINE_TABLE_BITS - 1;
  localparam logic [TONE_W-1:0] LAST_TONE = TONE_W'(NUM_TONES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_WAIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [MASK_W-1:0] enable_mask_q;
  logic [AMP_W-1:0]  amplitude_q;
  logic [STEP_W-1:0] step_q [NUM_TONES];
  logic [NUM_TONES-1:0] tone_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= ENABLE_MASK_RST;
      amplitude_q   <= AMPLITUDE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ENABLE_MASK) begin
        enable_mask_q <= cfg_data_i[MASK_W-1:0];
      end
      if (cfg_idx_i == REG_AMPLITUDE) begin
        amplitude_q <= cfg_data_i[AMP_W-1:0];
      end
    end
  end

  for (genvar j = 0; j < NUM_TONES; j++) begin : g_tone
    if (j < STEP_REGS) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          step_q[j] <= DEFAULT_STEPS[j];
        end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(REG_TONE0_STEP + j)) begin
          step_q[j] <= cfg_data_i[STEP_W-1:0];
        end
      end
      assign tone_en[j] = enable_mask_q[j];
    end else begin : g_fixed
      // tones past the sixth stay silent with a zero step
      assign step_q[j]  = '0;
      assign tone_en[j] = 1'b0;
    end
  end

  // quarter-wave table, entries past the quarter point are never addressed
  logic [SINE_W-1:0] qtab [1 << QA_W];
  for (genvar r = 0; r < (1 << QA_W); r++) begin : g_qtab
    if (r <= QUARTER) begin : g_val
      localparam logic [SINE_W-1:0] QV = quarter_sine(longint'(r), SINE_TABLE_BITS);
      assign qtab[r] = QV;
    end else begin : g_pad
      assign qtab[r] = '0;
    end
  end

  // phase memory with per-tone valid bits standing in for the zero reset
  logic [PHASE_BITS-1:0] phase_mem [NUM_TONES];
  logic [PHASE_BITS-1:0] ph_rd_q;
  logic [NUM_TONES-1:0]  ph_vld_q;

  logic              issue_act_q, issue_act_d;
  logic [TONE_W-1:0] issue_q, issue_d;

  logic              s1_vld_q, s1_last_q, s1_pv_q;
  logic [TONE_W-1:0] s1_idx_q;
  logic              s2_vld_q, s2_on_q, s2_neg_q, s2_last_q;
  logic [QA_W-1:0]   s2_addr_q;
  logic              s3_vld_q, s3_on_q, s3_neg_q, s3_last_q;
  logic [SINE_W-1:0] s3_qval_q;
  logic              s4_vld_q, s4_on_q, s4_neg_q, s4_last_q;
  logic [PROD_W-1:0] s4_prod_q;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [COUNT_W-1:0]      cnt_q, cnt_d;
  logic                    div_start_q, div_start_d;

  logic [PHASE_BITS-1:0]      phase_cur;
  logic [PHASE_BITS-1:0]      phase_nxt;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [QA_W-1:0]            r_ext;
  logic [QA_W-1:0]            tab_addr;

  logic [SUM_W-1:0] sum_abs;
  mtsm_div_req_t    div_req;
  mtsm_div_rsp_t    div_rsp;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [COUNT_W-1:0]         out_count_q;
  logic                       out_free;
  logic                       out_load;
  logic                       tick_acc;

  assign tick_acc = tick_valid_i && !tick_stall_o;
  assign out_free = !out_valid_q || !sample_stall_i;

  // stage 1: phase is back from memory, advance it and form the table address
  assign phase_cur = s1_pv_q ? ph_rd_q : '0;
  assign phase_nxt = phase_cur + PHASE_BITS'(step_q[s1_idx_q]);
  assign tab_idx   = phase_cur[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign r_ext     = {1'b0, tab_idx[SINE_TABLE_BITS-3:0]};
  // odd quadrants run the quarter wave backwards
  assign tab_addr  = tab_idx[SINE_TABLE_BITS-2] ? (QA_W'(QUARTER) - r_ext) : r_ext;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      phase_mem[s1_idx_q] <= phase_nxt;
    end
    ph_rd_q <= phase_mem[issue_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_vld_q <= '0;
    end else if (s1_vld_q) begin
      ph_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    issue_act_d = issue_act_q;
    issue_d     = issue_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    div_start_d = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (tick_acc && tick_i) begin
          state_d     = S_RUN;
          issue_act_d = 1'b1;
          issue_d     = '0;
          sum_d       = '0;
          cnt_d       = '0;
        end
      end
      S_RUN: begin
        if (issue_act_q) begin
          if (issue_q == LAST_TONE) begin
            issue_act_d = 1'b0;
          end else begin
            issue_d = issue_q + 1'b1;
          end
        end
        if (s4_vld_q && s4_on_q) begin
          if (s4_neg_q) begin
            sum_d = sum_q - $signed({{(SUM_W-PROD_W){1'b0}}, s4_prod_q});
          end else begin
            sum_d = sum_q + $signed({{(SUM_W-PROD_W){1'b0}}, s4_prod_q});
          end
          cnt_d = cnt_q + 1'b1;
        end
        if (s4_vld_q && s4_last_q) begin
          state_d     = S_DIV;
          div_start_d = 1'b1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_act_q <= 1'b0;
      issue_q     <= '0;
      div_start_q <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_act_q <= issue_act_d;
      issue_q     <= issue_d;
      div_start_q <= div_start_d;
      s1_vld_q    <= (state_q == S_RUN) && issue_act_q;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!sample_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= issue_q;
    s1_last_q <= (issue_q == LAST_TONE);
    s1_pv_q   <= ph_vld_q[issue_q];
    s2_on_q   <= tone_en[s1_idx_q];
    s2_neg_q  <= tab_idx[SINE_TABLE_BITS-1];
    s2_last_q <= s1_last_q;
    s2_addr_q <= tab_addr;
    s3_on_q   <= s2_on_q;
    s3_neg_q  <= s2_neg_q;
    s3_last_q <= s2_last_q;
    s3_qval_q <= qtab[s2_addr_q];
    s4_on_q   <= s3_on_q;
    s4_neg_q  <= s3_neg_q;
    s4_last_q <= s3_last_q;
    s4_prod_q <= amplitude_q * s3_qval_q;
    sum_q     <= sum_d;
    if (out_load) begin
      out_sample_q <= div_rsp.sample;
      out_count_q  <= cnt_q;
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign sum_abs       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_req.start = div_start_q;
  assign div_req.neg   = sum_q[SUM_W-1];
  assign div_req.numer = sum_abs[SUM_SHIFT +: DIV_NUM_W];
  assign div_req.denom = cnt_q;

  mtsm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign tick_stall_o   = (state_q != S_IDLE);
  assign sample_valid_o = out_valid_q;
  assign left_sample_o  = out_sample_q;
  assign right_sample_o = out_sample_q;
  assign active_tones_o = out_count_q;

endmodule

// ===== verif/tb.sv =====
// testbench for multi_tone_sine_mixer: directed and random ticks checked against a tone-mix predictor
module tb
  import mtsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TONES      = 6;
  localparam int TBITS      = SINE_TABLE_BITS_DEF;
  localparam int QUARTER    = 1 << (TBITS - 2);
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_s;
    logic signed [SAMPLE_W-1:0] right_s;
    logic [COUNT_W-1:0]         active;
  } sample_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       tick_valid_i;
  logic                       tick_stall_o;
  logic                       tick_i;
  logic                       sample_valid_o;
  logic                       sample_stall_i;
  logic signed [SAMPLE_W-1:0] left_sample_o;
  logic signed [SAMPLE_W-1:0] right_sample_o;
  logic [COUNT_W-1:0]         active_tones_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  // mirror of the mixer state
  logic [MASK_W-1:0] mask_q;
  logic [AMP_W-1:0]  amp_q;
  logic [31:0]       step_q  [TONES];
  logic [31:0]       phase_q [TONES];
  int                quarter_q15 [QUARTER + 1];

  sample_t predicted_samples [$];
  bit      no_idle;
  int      mismatches;
  int      samples_checked;
  int      configs_loaded;
  int      empty_ticks;
  longint  cycles;

  multi_tone_sine_mixer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_valid_i   (tick_valid_i),
    .tick_stall_o   (tick_stall_o),
    .tick_i         (tick_i),
    .sample_valid_o (sample_valid_o),
    .sample_stall_i (sample_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .active_tones_o (active_tones_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d samples still due", cycles,
               predicted_samples.size());
      $display("multi_tone_sine_mixer verification failed");
      $finish;
    end
  end

  // taylor series of sin to x^13 in q30, rounded to q15
  function automatic int taylor_q15(int r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    x    = (longint'(r) * HALF_PI_Q30) >> (TBITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return int'(v);
  endfunction

  function automatic int sine_q15(logic [TBITS-1:0] idx);
    int r;
    r = int'(idx[TBITS-3:0]);
    if (idx[TBITS-2]) r = QUARTER - r;
    return idx[TBITS-1] ? -quarter_q15[r] : quarter_q15[r];
  endfunction

  // one sample of the mix; every phase advances, enabled or not
  task automatic mix_next_sample(output sample_t s);
    longint acc;
    longint q;
    int     n_on;
    acc  = 0;
    n_on = 0;
    for (int j = 0; j < TONES; j++) begin
      if (mask_q[j]) begin
        acc = acc + longint'(amp_q) * longint'(sine_q15(phase_q[j][31 -: TBITS]));
        n_on++;
      end
      phase_q[j] = phase_q[j] + step_q[j];
    end
    q = 0;
    if (n_on > 0) begin
      q = acc / (longint'(n_on) * 32768);
      if (q > 32767)  q = 32767;
      if (q < -32767) q = -32767;
    end
    s.left_s  = q[SAMPLE_W-1:0];
    s.right_s = q[SAMPLE_W-1:0];
    s.active  = n_on[COUNT_W-1:0];
  endtask

  // called just after a rising edge; leaves valid high so ticks can go back to back
  task automatic send_tick(input logic t);
    sample_t s;
    while (!no_idle && $urandom_range(99) < 8) begin
      tick_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    tick_valid_i <= 1'b1;
    tick_i       <= t;
    do @(posedge clk_i); while (tick_stall_o);
    if (t) begin
      mix_next_sample(s);
      predicted_samples.push_back(s);
    end else begin
      empty_ticks++;
    end
  endtask

  // a dropped tick leaves no sample behind, so give the pipeline its latency on top
  task automatic wait_idle();
    tick_valid_i <= 1'b0;
    while (predicted_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [31:0] mask_word, input logic [31:0] amp_word,
                             input logic [TONES-1:0][31:0] steps);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ENABLE_MASK;
    cfg_data_i <= mask_word;
    @(posedge clk_i);
    mask_q     = mask_word[MASK_W-1:0];
    cfg_idx_i  <= REG_AMPLITUDE;
    cfg_data_i <= amp_word;
    @(posedge clk_i);
    amp_q = amp_word[AMP_W-1:0];
    for (int j = 0; j < TONES; j++) begin
      cfg_idx_i  <= REG_TONE0_STEP + CFG_IDX_W'(j);
      cfg_data_i <= steps[j];
      @(posedge clk_i);
      step_q[j] = steps[j];
    end
    cfg_we_i <= 1'b0;
    configs_loaded++;
  endtask

  task automatic load_random_config();
    logic [31:0]             mask_word;
    logic [31:0]             amp_word;
    logic [TONES-1:0][31:0]  steps;
    int                      pick;
    mask_word = $urandom;
    pick      = $urandom_range(9);
    if (pick == 0)      mask_word[MASK_W-1:0] = '0;
    else if (pick == 1) mask_word[MASK_W-1:0] = '1;
    amp_word = $urandom;
    pick     = $urandom_range(9);
    if (pick == 0)      amp_word[AMP_W-1:0] = '0;
    else if (pick <= 2) amp_word[AMP_W-1:0] = '1;
    for (int j = 0; j < TONES; j++) begin
      pick = $urandom_range(9);
      if (pick == 0)      steps[j] = '0;
      else if (pick == 1) steps[j] = '1;
      else if (pick <= 4) steps[j] = $urandom_range(32'h0010_0000);
      else                steps[j] = $urandom;
    end
    load_config(mask_word, amp_word, steps);
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 8; i++) send_tick(i != 4);
  endtask

  task automatic test_extremes();
    // quarter-turn steps on every tone, all enabled at full amplitude
    load_config(32'd63, 32'd32767, {TONES{32'h4000_0000}});
    for (int i = 0; i < 5; i++) send_tick(1'b1);
    // nothing enabled: zero out but phases still move
    load_config(32'hFFFF_FFC0, 32'h0000_7FFF, {TONES{32'hFFFF_FFFF}});
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    // amplitude field cleared, junk above it
    load_config(32'd63, 32'hFFFF_8000, {TONES{32'h1234_5678}});
    send_tick(1'b1);
    send_tick(1'b1);
    // single highest tone at full scale on a half-turn step
    load_config(32'h0000_0020, 32'd32767,
                {32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    for (int i = 0; i < 3; i++) send_tick(1'b1);
  endtask

  task automatic test_random_mix();
    int sent;
    for (int p = 0; p < 12; p++) begin
      load_random_config();
      sent = 0;
      while (sent < 92) begin
        if ($urandom_range(9) == 0) begin
          send_tick(1'b0);
        end else begin
          send_tick(1'b1);
          sent++;
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    load_random_config();
    no_idle = 1'b1;
    for (int i = 0; i < 200; i++) send_tick($urandom_range(19) != 0);
    wait_idle();
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_samples
    sample_t want;
    if (rst_ni && sample_valid_o && !sample_stall_i) begin
      if (predicted_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample L=%0d R=%0d n=%0d", left_sample_o, right_sample_o,
                   active_tones_o);
      end else begin
        want = predicted_samples.pop_front();
        samples_checked++;
        if (left_sample_o !== want.left_s || right_sample_o !== want.right_s ||
            active_tones_o !== want.active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample %0d: expected L=%0d R=%0d n=%0d, got L=%0d R=%0d n=%0d",
                     samples_checked, want.left_s, want.right_s, want.active,
                     left_sample_o, right_sample_o, active_tones_o);
        end
      end
    end
    sample_stall_i <= rst_ni && !no_idle && ($urandom_range(99) < 8);
  end

  initial begin
    rst_ni         = 1'b0;
    tick_valid_i   = 1'b0;
    tick_i         = 1'b0;
    sample_stall_i = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    no_idle        = 1'b0;
    for (int r = 0; r <= QUARTER; r++) quarter_q15[r] = taylor_q15(r);
    mask_q = ENABLE_MASK_RST;
    amp_q  = AMPLITUDE_RST;
    for (int j = 0; j < TONES; j++) begin
      step_q[j]  = DEFAULT_STEPS[j];
      phase_q[j] = '0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_extremes();
    test_random_mix();
    test_back_to_back();
    wait_idle();

    $display("checked %0d samples over %0d register settings, %0d empty ticks dropped",
             samples_checked, configs_loaded, empty_ticks);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0 && predicted_samples.size() == 0) begin
      $display("multi_tone_sine_mixer verification clean");
    end else begin
      $display("multi_tone_sine_mixer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mtsm_pkg.sv
src/mtsm_divider.sv
src/multi_tone_sine_mixer.sv
verif/tb.sv
